FILE: hdl/cgmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cgmc_pkg: shared types and constants for the gain/max compositor
// Pixel and result item structs, register indexes, reset values and the
// fixed-point constants of the divide-by-100 step.
// ----------------------------------------------------------------------------
package cgmc_pkg;

	localparam int unsigned ChanW  = 8;
	localparam int unsigned GainW  = 10;
	localparam int unsigned RouteW = 24;
	localparam int unsigned Lanes  = 3;

	// gain * x + 50 fits in 19 bits
	localparam int unsigned ProdW  = 19;
	// p >= 25600 saturates; below that p fits in 15 bits
	localparam int unsigned PLowW  = 15;
	localparam int unsigned RecipW = 34;
	localparam int unsigned RecipShift = 25;

	localparam logic [ProdW-1:0]  RoundAdd  = 19'd50;
	localparam logic [ProdW-1:0]  SatLimit  = 19'd25600;
	// ceil(2^25 / 100): exact floor(p / 100) for p below 2^25 / 68
	localparam logic [RecipW-1:0] RecipMul  = 34'd335545;

	localparam logic [GainW-1:0]  GainUnity = 10'd100;
	localparam logic [RouteW-1:0] RouteADef = 24'hFF0000;
	localparam logic [RouteW-1:0] RouteBDef = 24'h00FF00;
	localparam logic [RouteW-1:0] RouteCDef = 24'h0000FF;
	localparam logic [ChanW-1:0]  ChanMax   = 8'd255;

	typedef enum logic [2:0] {
		REG_GAIN_FIRST   = 3'd0,
		REG_ROUTE_FIRST  = 3'd1,
		REG_GAIN_SECOND  = 3'd2,
		REG_ROUTE_SECOND = 3'd3,
		REG_GAIN_THIRD   = 3'd4,
		REG_ROUTE_THIRD  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [ChanW-1:0] in_chan0;
		logic [ChanW-1:0] in_chan1;
		logic [ChanW-1:0] in_chan2;
		logic             last_pixel;
	} pixel_t;

	typedef struct packed {
		logic [ChanW-1:0] out_chan0;
		logic [ChanW-1:0] out_chan1;
		logic [ChanW-1:0] out_chan2;
		logic             end_of_image;
	} comp_t;

endpackage
`default_nettype wire

FILE: hdl/channel_gain_max_composite_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// channel_gain_max_composite_top: per-pixel gain, saturate and max compositor
// Scales each pixel byte by a percent gain with rounding, saturates at 255
// and merges the scaled bytes into output bytes by maximum under route words.
//
//   channel   direction  handshake              payload
//   pix       in         pix_valid / pix_stall  cgmc_pkg::pixel_t
//   comp      out        comp_valid / comp_stall cgmc_pkg::comp_t
//   cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while comp_stall is low. Stages: multiply,
// reciprocal multiply, saturate and merge. While every register holds its
// reset value the input pixel passes through unchanged. Reset clears the
// stage valid bits and loads the register defaults. Each stage holds only
// while it is full and the stage after it holds. cfg_ready is always high.
// ----------------------------------------------------------------------------
module channel_gain_max_composite_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire cgmc_pkg::pixel_t              pix,
	output logic                               comp_valid,
	input  wire logic                          comp_stall,
	output cgmc_pkg::comp_t                    comp,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [cgmc_pkg::RouteW-1:0]   cfg_data
);
	import cgmc_pkg::*;

	logic [GainW-1:0]  gain_q  [Lanes];
	logic [RouteW-1:0] route_q [Lanes];
	logic              bypass;

	logic              v_s1, v_s2, v_s3;
	logic              en1, en2, en3;
	logic [ProdW-1:0]  prod_s1  [Lanes];
	logic [RecipW-1:0] recip_s2 [Lanes];
	logic              sat_s2   [Lanes];
	pixel_t            pix_s1, pix_s2;
	comp_t             comp_s3;

	logic [ChanW-1:0]  xin    [Lanes];
	logic [ChanW-1:0]  scaled [Lanes];
	logic [ChanW-1:0]  acc    [Lanes];

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0]  <= GainUnity;
			gain_q[1]  <= GainUnity;
			gain_q[2]  <= GainUnity;
			route_q[0] <= RouteADef;
			route_q[1] <= RouteBDef;
			route_q[2] <= RouteCDef;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GAIN_FIRST:   gain_q[0]  <= cfg_data[GainW-1:0];
				REG_ROUTE_FIRST:  route_q[0] <= cfg_data;
				REG_GAIN_SECOND:  gain_q[1]  <= cfg_data[GainW-1:0];
				REG_ROUTE_SECOND: route_q[1] <= cfg_data;
				REG_GAIN_THIRD:   gain_q[2]  <= cfg_data[GainW-1:0];
				REG_ROUTE_THIRD:  route_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign bypass = (gain_q[0] == GainUnity) && (gain_q[1] == GainUnity) &&
		(gain_q[2] == GainUnity) && (route_q[0] == RouteADef) &&
		(route_q[1] == RouteBDef) && (route_q[2] == RouteCDef);

	// stage enables
	assign en3       = !v_s3 || !comp_stall;
	assign en2       = !v_s2 || en3;
	assign en1       = !v_s1 || en2;
	assign pix_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pix_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// lane 0 takes in_chan2, lane 2 takes in_chan0
	assign xin[0] = pix.in_chan2;
	assign xin[1] = pix.in_chan1;
	assign xin[2] = pix.in_chan0;

	// stage 1: gain multiply and rounding
	always_ff @(posedge clk) begin
		if (en1 && pix_valid) begin
			pix_s1 <= pix;
			for (int k = 0; k < Lanes; k++) begin
				prod_s1[k] <= ProdW'(gain_q[k]) * ProdW'(xin[k]) + RoundAdd;
			end
		end
	end

	// stage 2: reciprocal multiply for divide by 100, saturation flag
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			pix_s2 <= pix_s1;
			for (int k = 0; k < Lanes; k++) begin
				sat_s2[k]   <= prod_s1[k] >= SatLimit;
				recip_s2[k] <= RecipW'(prod_s1[k][PLowW-1:0]) * RecipMul;
			end
		end
	end

	// stage 3: saturate, route and take the maximum
	always_comb begin
		for (int k = 0; k < Lanes; k++) begin
			scaled[k] = sat_s2[k] ? ChanMax : recip_s2[k][RecipShift +: ChanW];
		end
		for (int j = 0; j < Lanes; j++) begin
			acc[j] = '0;
			for (int k = 0; k < Lanes; k++) begin
				if ((route_q[k][(Lanes-1-j)*ChanW +: ChanW] != '0) && (scaled[k] > acc[j]))
					acc[j] = scaled[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			comp_s3.end_of_image <= pix_s2.last_pixel;
			if (bypass) begin
				comp_s3.out_chan0 <= pix_s2.in_chan0;
				comp_s3.out_chan1 <= pix_s2.in_chan1;
				comp_s3.out_chan2 <= pix_s2.in_chan2;
			end else begin
				comp_s3.out_chan0 <= acc[0];
				comp_s3.out_chan1 <= acc[1];
				comp_s3.out_chan2 <= acc[2];
			end
		end
	end

	assign comp_valid = v_s3;
	assign comp       = comp_s3;

	// checks
	a_stall_needs_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> (v_s1 && v_s2 && v_s3 && comp_stall))
		else $error("input stalled with a free stage");

	a_recip_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !sat_s2[0]) |-> (recip_s2[0][RecipW-1:RecipShift+ChanW] == '0))
		else $error("reciprocal product out of range");

	a_unrouted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(comp_valid && !bypass && (route_q[0][23:16] == '0) &&
		(route_q[1][23:16] == '0) && (route_q[2][23:16] == '0))
		|-> (comp.out_chan0 == '0))
		else $error("unrouted output byte not zero");

	a_s3_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && !comp_stall) |=> v_s3)
		else $error("item dropped between stage 2 and stage 3");

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for channel_gain_max_composite_top
// A directed table covers bypass after reset, the lane swap under default
// routes, saturation, zero gain, unrouted lanes, masked gain writes and writes
// past the last register. Random pixels then run over a series of register
// settings under random idle and stall bursts. Each result is checked against
// its table value or a local model of the gain, saturate and max merge.
// ----------------------------------------------------------------------------
module tb;
	import cgmc_pkg::*;

	localparam logic [2:0] RegSpareLo = 3'd6;
	localparam logic [2:0] RegSpareHi = 3'd7;
	localparam int         NumRegs    = 6;
	localparam int         Phases     = 12;
	localparam int         PhaseItems = 112;

	typedef struct packed {
		logic              is_write;
		logic [2:0]        reg_idx;
		logic [RouteW-1:0] reg_val;
		pixel_t            px;
		logic              typed;
		comp_t             want;
	} step_row_t;

	logic              clk;
	logic              arst_n;
	logic              pix_valid;
	logic              pix_stall;
	pixel_t            pix;
	logic              comp_valid;
	logic              comp_stall = 1'b0;
	comp_t             comp;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [RouteW-1:0] cfg_data;

	logic [RouteW-1:0] reg_shadow [NumRegs];
	comp_t             pending_q [$];
	int                idle_pct      = 0;
	int                stall_left    = 0;
	int                mismatches    = 0;
	int                results_seen  = 0;
	int                pixels_sent   = 0;
	int                settings_used = 0;

	channel_gain_max_composite_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pix        (pix),
		.comp_valid (comp_valid),
		.comp_stall (comp_stall),
		.comp       (comp),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [ChanW-1:0] gained(logic [GainW-1:0] g, logic [ChanW-1:0] x);
		int unsigned q;
		q = (int'(g) * int'(x) + 50) / 100;
		return (q > 255) ? ChanMax : q[ChanW-1:0];
	endfunction

	function automatic comp_t composite(pixel_t p);
		logic [ChanW-1:0]  lvl [Lanes];
		logic [RouteW-1:0] rt  [Lanes];
		logic [ChanW-1:0]  acc [Lanes];
		comp_t             r;
		if (reg_shadow[REG_GAIN_FIRST][GainW-1:0] == GainUnity &&
				reg_shadow[REG_GAIN_SECOND][GainW-1:0] == GainUnity &&
				reg_shadow[REG_GAIN_THIRD][GainW-1:0] == GainUnity &&
				reg_shadow[REG_ROUTE_FIRST] == RouteADef &&
				reg_shadow[REG_ROUTE_SECOND] == RouteBDef &&
				reg_shadow[REG_ROUTE_THIRD] == RouteCDef) begin
			r = '{p.in_chan0, p.in_chan1, p.in_chan2, p.last_pixel};
		end else begin
			lvl[0] = gained(reg_shadow[REG_GAIN_FIRST][GainW-1:0], p.in_chan2);
			lvl[1] = gained(reg_shadow[REG_GAIN_SECOND][GainW-1:0], p.in_chan1);
			lvl[2] = gained(reg_shadow[REG_GAIN_THIRD][GainW-1:0], p.in_chan0);
			rt[0]  = reg_shadow[REG_ROUTE_FIRST];
			rt[1]  = reg_shadow[REG_ROUTE_SECOND];
			rt[2]  = reg_shadow[REG_ROUTE_THIRD];
			for (int lane = 0; lane < Lanes; lane++) begin
				acc[lane] = '0;
				for (int k = 0; k < Lanes; k++) begin
					if (rt[k][RouteW-1-ChanW*lane -: ChanW] != 0 && lvl[k] > acc[lane])
						acc[lane] = lvl[k];
				end
			end
			r = '{acc[0], acc[1], acc[2], p.last_pixel};
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [ChanW-1:0] want,
			logic [ChanW-1:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic step_row_t wr_row(logic [2:0] idx, logic [RouteW-1:0] val);
		step_row_t s;
		s          = '0;
		s.is_write = 1'b1;
		s.reg_idx  = idx;
		s.reg_val  = val;
		return s;
	endfunction

	function automatic step_row_t px_row(pixel_t p, logic typed, comp_t want);
		step_row_t s;
		s       = '0;
		s.px    = p;
		s.typed = typed;
		s.want  = want;
		return s;
	endfunction

	function automatic logic [RouteW-1:0] pick_gain();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return RouteW'(10'h3FF);
			2: return RouteW'(GainUnity);
			3: return RouteW'(GainUnity + 1);
			4: return RouteW'($urandom());
			default: return RouteW'($urandom_range(0, 1023));
		endcase
	endfunction

	function automatic logic [RouteW-1:0] pick_route(logic [RouteW-1:0] dflt);
		logic [RouteW-1:0] r;
		case ($urandom_range(0, 5))
			0: r = '0;
			1: r = '1;
			2: r = dflt;
			default: begin
				for (int b = 0; b < Lanes; b++)
					r[ChanW*b +: ChanW] = $urandom_range(0, 1) ?
						ChanW'($urandom_range(1, 255)) : '0;
			end
		endcase
		return r;
	endfunction

	function automatic logic [ChanW-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ChanMax;
			default: return ChanW'($urandom());
		endcase
	endfunction

	task automatic drain();
		while (pending_q.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [RouteW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_GAIN_FIRST, REG_GAIN_SECOND, REG_GAIN_THIRD: begin
				reg_shadow[idx] = RouteW'(val[GainW-1:0]);
			end
			REG_ROUTE_FIRST, REG_ROUTE_SECOND, REG_ROUTE_THIRD: begin
				reg_shadow[idx] = val;
			end
			default: ;
		endcase
	endtask

	task automatic send_pixel(input pixel_t p, input logic typed, input comp_t want);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pix       <= p;
		do @(posedge clk); while (pix_stall);
		pending_q.push_back(typed ? want : composite(p));
		pixels_sent++;
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			comp_stall <= 1'b1;
			stall_left--;
		end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			comp_stall <= 1'b1;
			stall_left = $urandom_range(0, 5);
		end else begin
			comp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		comp_t want;
		if (arst_n && comp_valid && !comp_stall) begin
			results_seen++;
			if (pending_q.size() == 0) begin
				$error("result %h arrived with no item pending", comp);
				mismatches++;
			end else begin
				want = pending_q.pop_front();
				check_field("out_chan0", want.out_chan0, comp.out_chan0);
				check_field("out_chan1", want.out_chan1, comp.out_chan1);
				check_field("out_chan2", want.out_chan2, comp.out_chan2);
				check_field("end_of_image", ChanW'(want.end_of_image),
					ChanW'(comp.end_of_image));
			end
		end
	end

	initial begin
		step_row_t         dir_steps [];
		logic [RouteW-1:0] setting [NumRegs];
		logic              writing;
		pixel_t            p;

		arst_n    <= 1'b0;
		pix_valid <= 1'b0;
		pix       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		reg_shadow[REG_GAIN_FIRST]   = RouteW'(GainUnity);
		reg_shadow[REG_ROUTE_FIRST]  = RouteADef;
		reg_shadow[REG_GAIN_SECOND]  = RouteW'(GainUnity);
		reg_shadow[REG_ROUTE_SECOND] = RouteBDef;
		reg_shadow[REG_GAIN_THIRD]   = RouteW'(GainUnity);
		reg_shadow[REG_ROUTE_THIRD]  = RouteCDef;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dir_steps = '{
			px_row(pixel_t'{8'h00, 8'h00, 8'h00, 1'b0}, 1'b1, comp_t'{8'h00, 8'h00, 8'h00, 1'b0}),
			px_row(pixel_t'{8'hFF, 8'hFF, 8'hFF, 1'b1}, 1'b1, comp_t'{8'hFF, 8'hFF, 8'hFF, 1'b1}),
			px_row(pixel_t'{8'h12, 8'h34, 8'h56, 1'b0}, 1'b1, comp_t'{8'h12, 8'h34, 8'h56, 1'b0}),
			px_row(pixel_t'{8'hA5, 8'h5A, 8'hC3, 1'b1}, 1'b1, comp_t'{8'hA5, 8'h5A, 8'hC3, 1'b1}),
			// off unity: default routes swap lanes 0 and 2
			wr_row(REG_GAIN_FIRST, 24'd101),
			px_row(pixel_t'{8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, '0),
			px_row(pixel_t'{8'hFF, 8'h80, 8'h01, 1'b1}, 1'b0, '0),
			wr_row(REG_GAIN_FIRST, 24'd1023),
			px_row(pixel_t'{8'h01, 8'h02, 8'hFF, 1'b0}, 1'b1, comp_t'{8'hFF, 8'h02, 8'h01, 1'b0}),
			px_row(pixel_t'{8'h00, 8'h00, 8'h1A, 1'b1}, 1'b0, '0),
			wr_row(REG_GAIN_SECOND, 24'd0),
			wr_row(REG_ROUTE_THIRD, 24'h000000),
			px_row(pixel_t'{8'hFF, 8'hFF, 8'hFF, 1'b0}, 1'b1, comp_t'{8'hFF, 8'h00, 8'h00, 1'b0}),
			wr_row(REG_ROUTE_FIRST, 24'hFFFFFF),
			wr_row(REG_ROUTE_SECOND, 24'h010101),
			px_row(pixel_t'{8'h40, 8'hFF, 8'h20, 1'b1}, 1'b0, '0),
			wr_row(REG_GAIN_THIRD, 24'd50),
			wr_row(REG_ROUTE_THIRD, 24'h800100),
			px_row(pixel_t'{8'hFF, 8'h10, 8'h30, 1'b0}, 1'b0, '0),
			px_row(pixel_t'{8'h01, 8'h00, 8'h00, 1'b1}, 1'b0, '0),
			// drop writes past the last register
			wr_row(RegSpareLo, 24'hFFFFFF),
			wr_row(RegSpareHi, 24'h000000),
			px_row(pixel_t'{8'hC8, 8'h64, 8'h32, 1'b0}, 1'b0, '0),
			// upper gain bits dropped: back to unity, then bypass with default routes
			wr_row(REG_GAIN_FIRST, 24'hFFFC64),
			wr_row(REG_ROUTE_FIRST, RouteADef),
			wr_row(REG_GAIN_SECOND, RouteW'(GainUnity)),
			wr_row(REG_ROUTE_SECOND, RouteBDef),
			wr_row(REG_GAIN_THIRD, RouteW'(GainUnity)),
			wr_row(REG_ROUTE_THIRD, RouteCDef),
			px_row(pixel_t'{8'h12, 8'h34, 8'h56, 1'b1}, 1'b1, comp_t'{8'h12, 8'h34, 8'h56, 1'b1}),
			wr_row(REG_ROUTE_THIRD, 24'h0000FE),
			px_row(pixel_t'{8'h12, 8'h34, 8'h56, 1'b0}, 1'b0, '0)
		};

		idle_pct = 20;
		writing  = 1'b0;
		foreach (dir_steps[i]) begin
			if (dir_steps[i].is_write) begin
				pix_valid <= 1'b0;
				if (!writing) begin
					drain();
					settings_used++;
				end
				writing = 1'b1;
				cfg_write(dir_steps[i].reg_idx, dir_steps[i].reg_val);
			end else begin
				if (writing)
					cfg_valid <= 1'b0;
				writing = 1'b0;
				send_pixel(dir_steps[i].px, dir_steps[i].typed, dir_steps[i].want);
			end
		end
		pix_valid <= 1'b0;
		cfg_valid <= 1'b0;

		for (int ph = 0; ph < Phases; ph++) begin
			case (ph)
				0: setting = '{RouteW'(GainUnity), RouteADef, RouteW'(GainUnity), RouteBDef,
						RouteW'(GainUnity), RouteCDef};
				1: setting = '{RouteW'(10'h3FF), '1, RouteW'(10'h3FF), '1, RouteW'(10'h3FF), '1};
				2: setting = '{'0, '0, '0, '0, '0, '0};
				3: setting = '{RouteW'(GainUnity), '1, RouteW'(GainUnity), '1,
						RouteW'(GainUnity), '1};
				default: setting = '{pick_gain(), pick_route(RouteADef), pick_gain(),
						pick_route(RouteBDef), pick_gain(), pick_route(RouteCDef)};
			endcase
			if (ph >= Phases - 2) begin
				idle_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			drain();
			if ($urandom_range(0, 2) == 0)
				cfg_write($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, RouteW'($urandom()));
			for (int k = 0; k < NumRegs; k++)
				cfg_write(cfg_idx_t'(k), setting[k]);
			cfg_valid <= 1'b0;
			settings_used++;
			for (int n = 0; n < PhaseItems; n++) begin
				p = '{rand_chan(), rand_chan(), rand_chan(), $urandom_range(0, 15) == 0};
				send_pixel(p, 1'b0, '0);
			end
			pix_valid <= 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("checked %0d results from %0d pixels over %0d register settings",
			results_seen, pixels_sent, settings_used);
		$display("covered bypass, lane swap, saturation, zero gain, unrouted lanes, masked writes");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: channel_gain_max_composite_top.f
hdl/cgmc_pkg.sv
hdl/channel_gain_max_composite_top.sv
sim/tb.sv
